// ===== rtl/owm_pkg.sv =====
package owm_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int FracBits           = 7;
   localparam int GuardBits          = 14;
   localparam int CordicGainQ16      = 39797;
   localparam int QuarterTurn        = 2304000;
   localparam int SnapWindowMs       = 500;
   localparam int StateMax           = 8388607;
   localparam int Cos30Q15           = 28378;
   localparam int Sin30Q15           = 16384;
   localparam int Cos140Q15          = 25102;
   localparam int Sin140Q15          = 21063;
   localparam int StepLengthReset    = 256;

   localparam logic [0:0] RegStepLength = 1'b0;
   localparam logic [0:0] RegChassis    = 1'b1;

   // CORDIC angle accumulator, 1/25600 degree
   typedef logic signed [25:0] angle_type;
   // CORDIC vector, speed << GuardBits plus growth
   typedef logic signed [32:0] cvec_type;
   // state vector, 1/32768 percent
   typedef logic signed [23:0] state_type;

   function automatic angle_type atan_lookup(input logic [4:0] idx);
      angle_type r;
      begin
         case (idx)
            5'd0:  r = 26'sd1152000;
            5'd1:  r = 26'sd680065;
            5'd2:  r = 26'sd359328;
            5'd3:  r = 26'sd182400;
            5'd4:  r = 26'sd91554;
            5'd5:  r = 26'sd45822;
            5'd6:  r = 26'sd22916;
            5'd7:  r = 26'sd11459;
            5'd8:  r = 26'sd5730;
            5'd9:  r = 26'sd2865;
            5'd10: r = 26'sd1432;
            5'd11: r = 26'sd716;
            5'd12: r = 26'sd358;
            5'd13: r = 26'sd179;
            5'd14: r = 26'sd90;
            5'd15: r = 26'sd45;
            5'd16: r = 26'sd22;
            5'd17: r = 26'sd11;
            5'd18: r = 26'sd6;
            5'd19: r = 26'sd3;
            5'd20: r = 26'sd1;
            5'd21: r = 26'sd1;
            default: r = 26'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== rtl/owm_cordic.sv =====
module owm_cordic #(
   parameter int CORDIC_STEPS = owm_pkg::CordicStepsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [14:0]            speed,
   input  logic signed [16:0]     hdg,
   output logic                   done,
   output owm_pkg::cvec_type      cos_out,
   output owm_pkg::cvec_type      sin_out
);
   import owm_pkg::*;

   localparam int IdxW = $clog2(CORDIC_STEPS + 1);

   logic              busy_ff, busy_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   cvec_type          c_ff, c_in, s_ff, s_in;
   angle_type         z_ff, z_in;
   cvec_type          v, dc, ds;
   angle_type         z0, at;
   logic [4:0]        idx5;

   assign idx5 = 5'(idx_ff);
   assign at   = atan_lookup(idx5);
   assign dc   = s_ff >>> idx_ff;
   assign ds   = c_ff >>> idx_ff;
   assign v    = cvec_type'({18'd0, speed}) <<< GuardBits;
   assign z0   = angle_type'(hdg) * 26'sd256;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      c_in    = c_ff;
      s_in    = s_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         if (z0 > angle_type'(QuarterTurn)) begin
            c_in = '0; s_in = v; z_in = z0 - angle_type'(QuarterTurn);
         end else if (z0 < -angle_type'(QuarterTurn)) begin
            c_in = '0; s_in = -v; z_in = z0 + angle_type'(QuarterTurn);
         end else begin
            c_in = v; s_in = '0; z_in = z0;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            c_in = c_ff - dc; s_in = s_ff + ds; z_in = z_ff - at;
         end else begin
            c_in = c_ff + dc; s_in = s_ff - ds; z_in = z_ff + at;
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == IdxW'(CORDIC_STEPS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      c_ff <= c_in;
      s_ff <= s_in;
      z_ff <= z_in;
   end

   assign done    = busy_ff && (idx_ff == IdxW'(CORDIC_STEPS - 1));
   assign cos_out = c_in;
   assign sin_out = s_in;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff < IdxW'(CORDIC_STEPS)) else $error("cordic index");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done |=> !busy_ff) else $error("cordic done");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("cordic restart");
endmodule

// ===== rtl/owm_sqrt.sv =====
module owm_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [49:0] radicand,
   output logic        done,
   output logic [24:0] root
);
   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [49:0] rem_ff, rem_in;
   logic [49:0] res_ff, res_in;
   logic [49:0] trial;
   logic [51:0] bitv;

   assign bitv  = 52'd1 << {cnt_ff, 1'b0};
   assign trial = res_ff + 50'(bitv);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd24;
         rem_in  = radicand;
         res_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + 50'(bitv);
         end else begin
            res_in = res_ff >> 1;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 5'd0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign done = busy_ff && cnt_ff == 5'd0;
   assign root = 25'(res_in);
endmodule

// ===== rtl/omni_wheel_mixer_with_slew.sv =====
// Four-wheel omni drive mixer with a slew-limited motion vector.
// Input channel req_*: one item is a motion command (heading, speed, turn,
// turn limit, now and start time in ms). It is taken when req_valid is high
// and req_stall is low. Result channel rsp_*: one item of four wheel speeds
// per command, held in an output register until taken (rsp_stall low).
// Registers on the csr_ APB port: step_length at 0x0, chassis_variant at 0x4.
// Each command runs a CORDIC_STEPS-step rotation CORDIC, a 25-step square
// root unless it snaps, a 33-step restoring divide for each axis when
// slewing, and a short multiply sequence for gain and four wheel terms, all
// on shared units. A snapping command skips the square root and divide, one
// landing on the wanted vector skips only the divide. The next item can be
// taken once the result is valid. One item is in flight at a time and
// req_stall is high while it works. A finished item waits in its last step
// while the previous result is still held, so req_stall stays high then.
// Reset clears the motion vector and the call-time memory, so the first
// command snaps, and loads step_length 256 and chassis_variant 0.
// While the receiver stalls, the result holds.
module omni_wheel_mixer_with_slew #(
   parameter int CORDIC_STEPS = owm_pkg::CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [16:0] req_heading_cdeg,
   input  logic [14:0]        req_speed,
   input  logic signed [15:0] req_turn,
   input  logic [14:0]        req_turn_limit,
   input  logic [31:0]        req_now_ms,
   input  logic [31:0]        req_start_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [16:0] rsp_wheel_one,
   output logic signed [16:0] rsp_wheel_two,
   output logic signed [16:0] rsp_wheel_three,
   output logic signed [16:0] rsp_wheel_four,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import owm_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CORD  = 4'd1;
   localparam logic [3:0] S_GAIN  = 4'd2;
   localparam logic [3:0] S_DIFF  = 4'd3;
   localparam logic [3:0] S_SQRT  = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_APPLY = 4'd6;
   localparam logic [3:0] S_WHEEL = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0]  st_ff;
   logic [3:0]  k_ff;
   logic [14:0] step_ff;
   logic        chassis_ff;
   logic [31:0] last_ff;
   state_type   cx_ff, cy_ff;
   logic signed [15:0] turn_ff;
   logic [14:0] lim_ff;
   logic        snap_ff;
   logic [31:0] now_ff;
   cvec_type    cc_ff, cs_ff;
   logic signed [25:0] wx_ff, wy_ff;
   logic signed [25:0] dx_ff, dy_ff;
   logic [49:0] l2_ff;
   logic [24:0] len_ff;
   logic signed [25:0] qx_ff, qy_ff;
   logic [63:0] num_ff;
   logic [31:0] quo_ff;
   logic [5:0]  dcnt_ff;
   logic signed [63:0] acc_ff;
   logic signed [16:0] wk_ff [4];
   logic signed [16:0] w_ff [4];
   logic        rv_ff;

   logic        take, cfg_wr;
   logic        cord_start, cord_done, sq_start, sq_done;
   cvec_type    cord_c, cord_s;
   logic [24:0] sq_root;
   logic signed [16:0] hdg_wrap;
   logic signed [15:0] turn_cl;

   // shared multiplier
   logic signed [33:0] ma, mb;
   logic signed [63:0] mp;
   assign mp = 64'(ma) * 64'(mb);

   assign take   = req_valid && !req_stall;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign req_stall  = (st_ff != S_IDLE);
   assign rsp_valid  = rv_ff;

   always_comb begin
      unique case (csr_paddr[2])
         RegStepLength: csr_prdata = {17'd0, step_ff};
         RegChassis:    csr_prdata = {31'd0, chassis_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      logic signed [17:0] h;
      h = 18'(req_heading_cdeg);
      if (h > 18'sd54000) h = h - 18'sd72000;
      else if (h > 18'sd18000) h = h - 18'sd36000;
      else if (h <= -18'sd54000) h = h + 18'sd72000;
      else if (h <= -18'sd18000) h = h + 18'sd36000;
      hdg_wrap = 17'(h);
   end

   assign cord_start = (st_ff == S_IDLE) && take;

   owm_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock, .reset,
      .start(cord_start), .speed(req_speed), .hdg(hdg_wrap),
      .done(cord_done), .cos_out(cord_c), .sin_out(cord_s)
   );

   assign sq_start = (st_ff == S_DIFF) && (k_ff == 4'd2);
   owm_sqrt u_sqrt (
      .clock, .reset, .start(sq_start), .radicand(l2_ff),
      .done(sq_done), .root(sq_root)
   );

   function automatic logic signed [25:0] rnd_shift(input logic signed [63:0] v,
                                                    input int s);
      logic signed [63:0] t;
      begin
         t = (v + (64'sd1 <<< (s - 1))) >>> s;
         return 26'(t);
      end
   endfunction

   function automatic state_type sat(input logic signed [25:0] v);
      begin
         if (v > 26'sd8388607) return 24'sd8388607;
         if (v < -26'sd8388607) return -24'sd8388607;
         return 24'(v);
      end
   endfunction

   always_comb begin
      if (turn_ff > $signed({1'b0, lim_ff})) turn_cl = $signed({1'b0, lim_ff});
      else if (turn_ff < -$signed({1'b0, lim_ff}))
         turn_cl = -$signed({1'b0, lim_ff});
      else turn_cl = turn_ff;
   end

   logic [31:0] dl;
   logic [63:0] dl2;
   logic [63:0] mag_x;
   assign dl  = {10'd0, step_ff, 7'd0};
   assign dl2 = 64'(dl) * 64'(dl);
   assign mag_x = (k_ff[0] ? (dy_ff < 0 ? 64'(-dy_ff) : 64'(dy_ff))
                           : (dx_ff < 0 ? 64'(-dx_ff) : 64'(dx_ff)));

   // multiplier operand selection
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (st_ff)
         S_GAIN: begin
            ma = (k_ff == 4'd0) ? 34'(cs_ff) : 34'(cc_ff);
            mb = 34'sd39797;
         end
         S_DIFF: begin
            ma = (k_ff == 4'd0) ? 34'(dx_ff) : 34'(dy_ff);
            mb = ma;
         end
         S_DIV: begin
            ma = 34'(mag_x);
            mb = 34'(dl);
         end
         S_WHEEL: begin
            ma = k_ff[0] ? 34'(cx_ff) : 34'(cy_ff);
            unique case (k_ff[2:1])
               2'd0: mb = k_ff[0] ? 34'sd16384  : 34'sd28378;
               2'd1: mb = k_ff[0] ? 34'sd21063  : -34'sd25102;
               2'd2: mb = k_ff[0] ? -34'sd21063 : -34'sd25102;
               default: mb = k_ff[0] ? -34'sd16384 : 34'sd28378;
            endcase
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   logic [5:0]  div_sh;
   logic        div_ge;
   logic [31:0] quo_nx;
   assign div_sh = 6'd33 - dcnt_ff;
   assign div_ge = (num_ff >> div_sh) >= 64'(len_ff);
   assign quo_nx = div_ge ? (quo_ff | (32'd1 << div_sh)) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= S_IDLE;
         k_ff       <= '0;
         rv_ff      <= 1'b0;
         step_ff    <= 15'(StepLengthReset);
         chassis_ff <= 1'b0;
         last_ff    <= '0;
         cx_ff      <= '0;
         cy_ff      <= '0;
      end else begin
         if (cfg_wr) begin
            if (csr_paddr[2] == RegStepLength) step_ff <= csr_pwdata[14:0];
            else chassis_ff <= csr_pwdata[0];
         end
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (take) begin
               turn_ff  <= req_turn;
               lim_ff   <= req_turn_limit;
               now_ff   <= req_now_ms;
               snap_ff  <= (last_ff == 32'd0)
                           || ((req_now_ms - req_start_ms) < 32'(SnapWindowMs));
               st_ff    <= S_CORD;
            end
            S_CORD: if (cord_done) begin
               cc_ff <= cord_c;
               cs_ff <= cord_s;
               k_ff  <= '0;
               st_ff <= S_GAIN;
            end
            S_GAIN: begin
               if (k_ff == 4'd0) begin
                  wx_ff <= rnd_shift(mp, 16 + GuardBits - FracBits);
                  k_ff  <= 4'd1;
               end else begin
                  wy_ff <= rnd_shift(mp, 16 + GuardBits - FracBits);
                  dx_ff <= wx_ff - 26'(cx_ff);
                  dy_ff <= rnd_shift(mp, 16 + GuardBits - FracBits) - 26'(cy_ff);
                  k_ff  <= '0;
                  st_ff <= S_DIFF;
                  if (snap_ff) begin
                     cx_ff <= 24'(wx_ff);
                     cy_ff <= 24'(rnd_shift(mp, 16 + GuardBits - FracBits));
                     st_ff <= S_WHEEL;
                  end
               end
            end
            S_DIFF: begin
               if (k_ff == 4'd0) begin
                  l2_ff <= 50'(mp);
                  k_ff  <= 4'd1;
               end else if (k_ff == 4'd1) begin
                  l2_ff <= l2_ff + 50'(mp);
                  k_ff  <= 4'd2;
               end else begin
                  st_ff <= S_SQRT;
               end
            end
            S_SQRT: if (sq_done) begin
               len_ff <= sq_root;
               if ((64'(l2_ff) > dl2) && (sq_root != 25'd0)) begin
                  k_ff    <= '0;
                  dcnt_ff <= '0;
                  st_ff   <= S_DIV;
               end else begin
                  cx_ff <= 24'(wx_ff);
                  cy_ff <= 24'(wy_ff);
                  k_ff  <= '0;
                  st_ff <= S_WHEEL;
               end
            end
            S_DIV: begin
               // restoring divide of mag*dl + len/2 by len, one bit a cycle
               if (dcnt_ff == 6'd0) begin
                  num_ff  <= 64'(mp) + 64'(len_ff >> 1);
                  quo_ff  <= '0;
                  dcnt_ff <= 6'd1;
               end else begin
                  if (div_ge) num_ff <= num_ff - (64'(len_ff) << div_sh);
                  quo_ff <= quo_nx;
                  if (dcnt_ff == 6'd33) begin
                     dcnt_ff <= '0;
                     if (k_ff[0] == 1'b0) begin
                        qx_ff <= (dx_ff < 0) ? -26'(quo_nx) : 26'(quo_nx);
                        k_ff  <= 4'd1;
                     end else begin
                        qy_ff <= (dy_ff < 0) ? -26'(quo_nx) : 26'(quo_nx);
                        st_ff <= S_APPLY;
                     end
                  end else begin
                     dcnt_ff <= dcnt_ff + 1'b1;
                  end
               end
            end
            S_APPLY: begin
               cx_ff <= sat(26'(cx_ff) + qx_ff);
               cy_ff <= sat(26'(cy_ff) + qy_ff);
               k_ff  <= '0;
               st_ff <= S_WHEEL;
            end
            S_WHEEL: begin
               if (k_ff[0] == 1'b0) begin
                  acc_ff <= mp;
               end else begin
                  logic signed [25:0] t;
                  t = rnd_shift(acc_ff - mp, 15 + FracBits) ;
                  unique case (k_ff[2:1])
                     2'd0: wk_ff[0] <= 17'(-(t + 26'(turn_cl)));
                     2'd1: wk_ff[1] <= 17'(-(t - 26'(turn_cl)));
                     2'd2: wk_ff[2] <= 17'(t + 26'(turn_cl));
                     default: wk_ff[3] <= chassis_ff ? 17'(t - 26'(turn_cl))
                                                     : 17'(-(t - 26'(turn_cl)));
                  endcase
               end
               if (k_ff == 4'd7) begin
                  st_ff <= S_OUT;
               end
               k_ff <= k_ff + 1'b1;
            end
            S_OUT: if (!rv_ff) begin
               rv_ff   <= 1'b1;
               w_ff[0] <= wk_ff[0];
               w_ff[1] <= wk_ff[1];
               w_ff[2] <= wk_ff[2];
               w_ff[3] <= wk_ff[3];
               last_ff <= now_ff;
               st_ff   <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_wheel_one   = w_ff[0];
   assign rsp_wheel_two   = w_ff[1];
   assign rsp_wheel_three = w_ff[2];
   assign rsp_wheel_four  = w_ff[3];

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      take |=> st_ff == S_CORD) else $error("item not started");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff && $stable(rsp_wheel_one)) else $error("result lost");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IDLE |-> req_stall) else $error("accept while busy");
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import owm_pkg::*;

   typedef struct packed {
      logic signed [16:0] heading;
      logic [14:0]        speed;
      logic signed [15:0] turn;
      logic [14:0]        turn_limit;
      logic [31:0]        now_ms;
      logic [31:0]        start_ms;
   } command_type;

   typedef struct packed {
      logic signed [16:0] w1;
      logic signed [16:0] w2;
      logic signed [16:0] w3;
      logic signed [16:0] w4;
   } wheels_type;

   localparam int NumRandom = 950;
   localparam longint CycleLimit = 2000000;
   localparam int LongHold = 400;
   localparam logic [2:0] AddrStepLength = {RegStepLength, 2'b00};
   localparam logic [2:0] AddrChassis    = {RegChassis, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [16:0] req_heading_cdeg = '0;
   logic [14:0] req_speed = '0;
   logic signed [15:0] req_turn = '0;
   logic [14:0] req_turn_limit = '0;
   logic [31:0] req_now_ms = '0;
   logic [31:0] req_start_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [16:0] rsp_wheel_one, rsp_wheel_two, rsp_wheel_three, rsp_wheel_four;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   omni_wheel_mixer_with_slew dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // predictor state
   longint cur_x, cur_y;
   logic [31:0] last_call;
   logic [14:0] step_len;
   logic chassis;

   command_type pending_cmds[$];
   wheels_type  expected_wheels[$];

   int mismatches = 0;
   int failures = 0;
   longint cycles = 0;
   bit quiet_idle = 0;
   bit stall_hold = 0;
   int hold_cycles = 0;
   bit hold_request = 0;
   bit accepted_last = 0;

   function automatic longint asr64(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint rnd_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint sat_st(longint v);
      if (v > StateMax) return StateMax;
      if (v < -StateMax) return -StateMax;
      return v;
   endfunction

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint slew_part(longint d, longint unsigned lim, longint unsigned len);
      longint unsigned mag;
      longint q;
      mag = d < 0 ? -d : d;
      q = (mag * lim + len / 2) / len;
      return d < 0 ? -q : q;
   endfunction

   function automatic longint wheel_mix(longint c, longint s);
      return rnd_shift(cur_y * c - cur_x * s, 15 + FracBits);
   endfunction

   task automatic predict_wheels(input command_type c);
      longint hdg, turn, lim, z, v, cv, sv, dc, ds, wx, wy, dx, dy, s1, s2, s3, s4;
      longint unsigned l2, dl, len;
      wheels_type w;
      hdg = c.heading;
      turn = c.turn;
      lim = c.turn_limit;
      hdg = hdg % 36000;
      if (hdg < 0) hdg += 36000;
      if (hdg > 18000) hdg -= 36000;
      z = hdg * 256;
      v = longint'(c.speed) << GuardBits;
      cv = v;
      sv = 0;
      if (z > QuarterTurn) begin
         cv = 0; sv = v; z -= QuarterTurn;
      end else if (z < -QuarterTurn) begin
         cv = 0; sv = -v; z += QuarterTurn;
      end
      for (int i = 0; i < CordicStepsDefault; i++) begin
         dc = asr64(sv, i);
         ds = asr64(cv, i);
         if (z >= 0) begin
            cv -= dc; sv += ds; z -= atan_lookup(5'(i));
         end else begin
            cv += dc; sv -= ds; z += atan_lookup(5'(i));
         end
      end
      wx = rnd_shift(sv * CordicGainQ16, 16 + GuardBits - FracBits);
      wy = rnd_shift(cv * CordicGainQ16, 16 + GuardBits - FracBits);
      if (last_call == 0 || (c.now_ms - c.start_ms) < SnapWindowMs) begin
         cur_x = wx;
         cur_y = wy;
      end else begin
         dx = wx - cur_x;
         dy = wy - cur_y;
         l2 = dx * dx + dy * dy;
         dl = longint'(step_len) << FracBits;
         len = isqrt(l2);
         if (l2 > dl * dl && len != 0) begin
            cur_x = sat_st(cur_x + slew_part(dx, dl, len));
            cur_y = sat_st(cur_y + slew_part(dy, dl, len));
         end else begin
            cur_x = wx;
            cur_y = wy;
         end
      end
      if (turn > lim) turn = lim;
      else if (turn < -lim) turn = -lim;
      s1 = wheel_mix(Cos30Q15, Sin30Q15) + turn;
      s2 = wheel_mix(-Cos140Q15, Sin140Q15) - turn;
      s3 = wheel_mix(-Cos140Q15, -Sin140Q15) + turn;
      s4 = wheel_mix(Cos30Q15, -Sin30Q15) - turn;
      w.w1 = 17'(-s1);
      w.w2 = 17'(-s2);
      w.w3 = 17'(s3);
      w.w4 = chassis ? 17'(s4) : 17'(-s4);
      expected_wheels.push_back(w);
      last_call = c.now_ms;
   endtask

   function automatic bit idle_roll();
      return !quiet_idle && ($urandom_range(99) < 13);
   endfunction

   // sender
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted_last) begin
            if (pending_cmds.size() > 0 && !hold_request && !idle_roll()) begin
               command_type c;
               c = pending_cmds[0];
               req_valid <= 1'b1;
               req_heading_cdeg <= c.heading;
               req_speed <= c.speed;
               req_turn <= c.turn;
               req_turn_limit <= c.turn_limit;
               req_now_ms <= c.now_ms;
               req_start_ms <= c.start_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      accepted_last <= 1'b0;
      if (!reset && req_valid && !req_stall) begin
         accepted_last <= 1'b1;
         predict_wheels(pending_cmds.pop_front());
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (stall_hold && hold_cycles < LongHold) begin
         hold_cycles <= hold_cycles + 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_roll();
      end
   end

   // result monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         wheels_type got, exp_w;
         got = '{rsp_wheel_one, rsp_wheel_two, rsp_wheel_three, rsp_wheel_four};
         if (expected_wheels.size() == 0) begin
            failures++;
            if (mismatches < 10) $display("unexpected result %p", got);
            mismatches++;
         end else begin
            exp_w = expected_wheels.pop_front();
            if (got !== exp_w) begin
               failures++;
               if (mismatches < 10)
                  $display("mismatch: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                     exp_w.w1, exp_w.w2, exp_w.w3, exp_w.w4,
                     got.w1, got.w2, got.w3, got.w4);
               mismatches++;
            end
         end
      end
      if (cycles > CycleLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == AddrStepLength) step_len = data[14:0];
      else chassis = data[0];
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || expected_wheels.size() > 0) @(posedge clock);
      repeat (CordicStepsDefault + 130) @(posedge clock);
   endtask

   function automatic command_type rand_cmd(input logic [31:0] t, input bit snap);
      command_type c;
      int r;
      r = $urandom_range(99);
      c.heading = (r < 85) ? 17'($urandom_range(36000) - 18000)
                           : 17'($urandom_range(72000) - 36000);
      if (r > 95) c.heading = 17'($urandom);
      c.speed = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(25600));
      c.turn = ($urandom_range(9) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(51200) - 25600);
      c.turn_limit = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(25600));
      c.now_ms = t;
      c.start_ms = snap ? t - $urandom_range(499) : t - 500 - $urandom_range(100000);
      if ($urandom_range(19) == 0) c.start_ms = $urandom;
      if ($urandom_range(49) == 0) c.now_ms = 0;
      return c;
   endfunction

   initial begin
      logic [31:0] t;
      command_type c;
      cur_x = 0; cur_y = 0; last_call = 0;
      step_len = 15'(StepLengthReset);
      chassis = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      t = 32'd1000;
      c = '{17'sd0, 15'd25600, 16'sd25600, 15'd25600, t, t};
      pending_cmds.push_back(c);
      c = '{17'sd18000, 15'd0, -16'sd25600, 15'd0, t + 600, t};
      pending_cmds.push_back(c);
      c = '{-17'sd36000, 15'd25600, -16'sd25600, 15'd25600, t + 700, t};
      pending_cmds.push_back(c);
      c = '{17'sd36000, 15'h7fff, 16'sh7fff, 15'h7fff, t + 800, t};
      pending_cmds.push_back(c);
      c = '{-17'sd65536, 15'h7fff, -16'sd32768, 15'd100, 32'hffffffff, 32'd5};
      pending_cmds.push_back(c);
      c = '{17'sd65535, 15'd12000, 16'sd300, 15'd200, 32'd0, 32'hfffffff0};
      pending_cmds.push_back(c);
      c = '{-17'sd18000, 15'd25600, 16'sd0, 15'd0, 32'd3, 32'hfffffffe};
      pending_cmds.push_back(c);
      c = '{17'sd9000, 15'd25600, 16'sd100, 15'd25600, 32'd90000, 32'd1};
      pending_cmds.push_back(c);
      c = '{-17'sd9000, 15'd25600, 16'sd100, 15'd25600, 32'd90100, 32'd1};
      pending_cmds.push_back(c);
      wait_drained();
      csr_write(AddrStepLength, 32'd0);
      csr_write(AddrChassis, 32'd1);
      c = '{17'sd4500, 15'd20000, 16'sd50, 15'd40, 32'd200000, 32'd1};
      pending_cmds.push_back(c);
      c = '{17'sd4500, 15'd20000, 16'sd50, 15'd40, 32'd0, 32'd1};
      pending_cmds.push_back(c);
      c = '{-17'sd13500, 15'd20000, 16'sd50, 15'd40, 32'd7, 32'd1};
      pending_cmds.push_back(c);
      wait_drained();

      // random phases across settings
      t = 32'd5000;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: csr_write(AddrStepLength, 32'd25600);
            1: csr_write(AddrStepLength, 32'd256);
            2: csr_write(AddrChassis, 32'd0);
            3: csr_write(AddrStepLength, 32'h7fff);
            4: csr_write(AddrStepLength, $urandom_range(2000));
            default: csr_write(AddrChassis, 32'd1);
         endcase
         quiet_idle = (ph == 2);
         for (int i = 0; i < NumRandom / 6; i++) begin
            t += $urandom_range(1, 20);
            pending_cmds.push_back(rand_cmd(t, $urandom_range(9) < 2));
         end
         if (ph == 1) begin
            stall_hold = 1;
            wait (hold_cycles >= LongHold);
            stall_hold = 0;
         end
         if (ph == 3) begin
            while (pending_cmds.size() > NumRandom / 12) @(posedge clock);
            hold_request = 1;
            while (expected_wheels.size() > 0) @(posedge clock);
            hold_request = 0;
         end
         wait_drained();
      end
      quiet_idle = 0;

      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
